/* rtl/tsm_pkg.sv */
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the typed stack machine step block.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_COUNT = 16;

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int LIDX_W  = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int MODE_W  = 4;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 8;
    localparam int IP_W    = 16;
    localparam int STAT_W  = 3;
    localparam int DEPTH_W = 7;

    // opcodes
    localparam logic [MODE_W-1:0] OP_NOP   = 4'd0;
    localparam logic [MODE_W-1:0] OP_DUP   = 4'd1;
    localparam logic [MODE_W-1:0] OP_POP   = 4'd2;
    localparam logic [MODE_W-1:0] OP_LDC   = 4'd3;
    localparam logic [MODE_W-1:0] OP_ADD   = 4'd4;
    localparam logic [MODE_W-1:0] OP_SUB   = 4'd5;
    localparam logic [MODE_W-1:0] OP_MUL   = 4'd6;
    localparam logic [MODE_W-1:0] OP_LDLOC = 4'd7;
    localparam logic [MODE_W-1:0] OP_STLOC = 4'd8;
    localparam logic [MODE_W-1:0] OP_BR    = 4'd9;
    localparam logic [MODE_W-1:0] OP_RET   = 4'd10;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDER  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVER   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_TYPE   = 3'd4;

    // tagged value: tag set means the entry holds an integer, clear means null
    typedef struct packed {
        logic              tag;
        logic [DATA_W-1:0] val;
    } entry_t;

    // what one stack cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_UP,
        CELL_TAKE_DN1,
        CELL_TAKE_DN2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t top_cmd;
        cell_cmd_t rest_cmd;
        entry_t    new_top;
    } stack_ctl_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [IP_W-1:0]    instr_pointer;
        logic [DEPTH_W-1:0] depth;
        logic [DATA_W-1:0]  top_value;
        logic               top_is_int;
    } result_t;

endpackage

/* rtl/tsm_if.sv */
// ----------------------------------------------------------------------------
// tsm_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface tsm_in_if import tsm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [DATA_W-1:0]  immediate;
    logic [INDEX_W-1:0]        local_index;
    logic [IP_W-1:0]           jump_target;

    modport source (output valid, output mode, output immediate, output local_index,
                    output jump_target, input ready);
    modport sink   (input valid, input mode, input immediate, input local_index,
                    input jump_target, output ready);
endinterface

interface tsm_out_if import tsm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic [IP_W-1:0]           instr_pointer;
    logic [DEPTH_W-1:0]        depth;
    logic signed [DATA_W-1:0]  top_value;
    logic                      top_is_int;

    modport source (output valid, output status, output instr_pointer, output depth,
                    output top_value, output top_is_int, input ready);
    modport sink   (input valid, input status, input instr_pointer, input depth,
                    input top_value, input top_is_int, output ready);
endinterface

/* rtl/typed_stack_machine_step.sv */
// ----------------------------------------------------------------------------
// typed_stack_machine_step
// Executes one typed stack bytecode instruction per instruction beat.
// ----------------------------------------------------------------------------
// Each result is registered, in the output stage or, if that is held, the skid entry.
// Throughput: one instruction per cycle while the skid entry is free; the stack cells
// shift at most once per instruction and the single 32x32 multiplier feeds the top cell directly.
// A two-entry result buffer keeps instructions flowing while a result waits.
// Reset: stack empty, locals null, instruction pointer zero; no clearing pass.
// ----------------------------------------------------------------------------
module typed_stack_machine_step import tsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tsm_in_if.sink    instr,
    tsm_out_if.source result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IP_W-1:0]  ip_reg;
    logic [IP_W-1:0]  ip_next;

    entry_t     s0;
    entry_t     s1;
    entry_t     s2;
    entry_t     loc_rd;
    entry_t     top_next;
    stack_ctl_t ctl_dec;
    stack_ctl_t ctl;
    logic       loc_we;
    logic [STAT_W-1:0] status_dec;

    logic        accept;
    logic        idx_ok;
    logic        empty;
    logic        full;
    logic        lt2;
    logic [DATA_W-1:0] arith;

    result_t res_new;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign instr.ready = !skid_valid_reg;
    assign accept      = instr.valid && instr.ready;
    assign pop         = out_valid_reg && result.ready;

    assign idx_ok = {1'b0, instr.local_index} < (INDEX_W + 1)'(LOCAL_COUNT);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg >= CNT_W'(STACK_DEPTH));
    assign lt2    = (count_reg < CNT_W'(2));

    always_comb
    begin
        case (instr.mode)
            OP_ADD:  arith = s0.val + s1.val;
            OP_SUB:  arith = s1.val - s0.val;
            default: arith = s0.val * s1.val;
        endcase
    end

    always_comb
    begin
        status_dec       = ST_OK;
        count_next       = count_reg;
        ip_next          = ip_reg;
        ctl_dec.top_cmd  = CELL_HOLD;
        ctl_dec.rest_cmd = CELL_HOLD;
        ctl_dec.new_top  = '0;
        loc_we           = 1'b0;
        top_next         = s0;

        case (instr.mode)
            OP_NOP:
            begin
                ip_next = ip_reg + 1'b1;
            end
            OP_DUP:
            begin
                if (empty)
                    status_dec = ST_UNDER;
                else if (full)
                    status_dec = ST_OVER;
                else
                begin
                    ctl_dec.top_cmd  = CELL_TAKE_UP;
                    ctl_dec.rest_cmd = CELL_TAKE_UP;
                    ctl_dec.new_top  = s0;
                    count_next       = count_reg + 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty)
                    status_dec = ST_UNDER;
                else
                begin
                    ctl_dec.top_cmd  = CELL_TAKE_DN1;
                    ctl_dec.rest_cmd = CELL_TAKE_DN1;
                    top_next         = s1;
                    count_next       = count_reg - 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_LDC:
            begin
                if (full)
                    status_dec = ST_OVER;
                else
                begin
                    ctl_dec.top_cmd  = CELL_TAKE_UP;
                    ctl_dec.rest_cmd = CELL_TAKE_UP;
                    ctl_dec.new_top  = '{tag: 1'b1, val: instr.immediate};
                    top_next         = ctl_dec.new_top;
                    count_next       = count_reg + 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_ADD, OP_SUB, OP_MUL:
            begin
                if (lt2)
                    status_dec = ST_UNDER;
                else if (!(s0.tag && s1.tag))
                begin
                    // drop both operands, push nothing
                    status_dec       = ST_TYPE;
                    ctl_dec.top_cmd  = CELL_TAKE_DN2;
                    ctl_dec.rest_cmd = CELL_TAKE_DN2;
                    top_next         = s2;
                    count_next       = count_reg - CNT_W'(2);
                end
                else
                begin
                    ctl_dec.top_cmd  = CELL_TAKE_UP;
                    ctl_dec.rest_cmd = CELL_TAKE_DN1;
                    ctl_dec.new_top  = '{tag: 1'b1, val: arith};
                    top_next         = ctl_dec.new_top;
                    count_next       = count_reg - 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_LDLOC:
            begin
                if (!idx_ok)
                    status_dec = ST_BADLOC;
                else if (full)
                    status_dec = ST_OVER;
                else
                begin
                    ctl_dec.top_cmd  = CELL_TAKE_UP;
                    ctl_dec.rest_cmd = CELL_TAKE_UP;
                    ctl_dec.new_top  = loc_rd;
                    top_next         = loc_rd;
                    count_next       = count_reg + 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_STLOC:
            begin
                if (!idx_ok)
                    status_dec = ST_BADLOC;
                else if (empty)
                    status_dec = ST_UNDER;
                else
                begin
                    loc_we           = 1'b1;
                    ctl_dec.top_cmd  = CELL_TAKE_DN1;
                    ctl_dec.rest_cmd = CELL_TAKE_DN1;
                    top_next         = s1;
                    count_next       = count_reg - 1'b1;
                    ip_next          = ip_reg + 1'b1;
                end
            end
            OP_BR:
            begin
                ip_next = instr.jump_target;
            end
            OP_RET:
            begin
                ip_next = ip_reg;
            end
            default:
            begin
                status_dec = ST_TYPE;
            end
        endcase
    end

    // gate every state change on an accepted beat
    always_comb
    begin
        ctl = ctl_dec;
        if (!accept)
        begin
            ctl.top_cmd  = CELL_HOLD;
            ctl.rest_cmd = CELL_HOLD;
        end
    end

    tsm_stack u_stack (
        .clk (clk),
        .ctl (ctl),
        .s0  (s0),
        .s1  (s1),
        .s2  (s2)
    );

    tsm_locals u_locals (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (instr.local_index[LIDX_W-1:0]),
        .we    (loc_we && accept),
        .wdata (s0),
        .rdata (loc_rd)
    );

    always_comb
    begin
        res_new.status        = status_dec;
        res_new.instr_pointer = ip_next;
        res_new.depth         = DEPTH_W'(count_next);
        res_new.top_is_int    = (count_next != '0) && top_next.tag;
        res_new.top_value     = res_new.top_is_int ? top_next.val : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ip_reg    <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            ip_reg    <= ip_next;
        end
    end

    // result buffer: output stage plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (accept)
                    skid_reg <= res_new;
            end
            else if (accept)
            begin
                out_reg <= res_new;
            end
        end
        else if (accept)
        begin
            skid_reg <= res_new;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_reg.status;
    assign result.instr_pointer = out_reg.instr_pointer;
    assign result.depth         = out_reg.depth;
    assign result.top_value     = out_reg.top_value;
    assign result.top_is_int    = out_reg.top_is_int;

endmodule

/* rtl/tsm_cell.sv */
// ----------------------------------------------------------------------------
// tsm_cell
// One operand stack slot; takes its neighbor's entry on push or pop, or the entry two below on a double pop.
// ----------------------------------------------------------------------------
module tsm_cell import tsm_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  entry_t    up,
    input  entry_t    dn1,
    input  entry_t    dn2,
    output entry_t    q
);

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        case (cmd)
            CELL_TAKE_UP:  q_reg <= up;
            CELL_TAKE_DN1: q_reg <= dn1;
            CELL_TAKE_DN2: q_reg <= dn2;
            default:       q_reg <= q_reg;
        endcase
    end

    assign q = q_reg;

endmodule

/* rtl/tsm_stack.sv */
// ----------------------------------------------------------------------------
// tsm_stack
// Operand stack as a row of cells, top at cell zero.
// ----------------------------------------------------------------------------
module tsm_stack import tsm_pkg::*;
(
    input  logic       clk,
    input  stack_ctl_t ctl,
    output entry_t     s0,
    output entry_t     s1,
    output entry_t     s2
);

    entry_t q [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        entry_t    up_i;
        entry_t    dn1_i;
        entry_t    dn2_i;
        cell_cmd_t cmd_i;

        if (i == 0)
        begin : g_top
            assign up_i  = ctl.new_top;
            assign cmd_i = ctl.top_cmd;
        end
        else
        begin : g_mid
            assign up_i  = q[i-1];
            assign cmd_i = ctl.rest_cmd;
        end

        if (i + 1 < STACK_DEPTH)
        begin : g_dn1
            assign dn1_i = q[i+1];
        end
        else
        begin : g_dn1_end
            assign dn1_i = '0;
        end

        if (i + 2 < STACK_DEPTH)
        begin : g_dn2
            assign dn2_i = q[i+2];
        end
        else
        begin : g_dn2_end
            assign dn2_i = '0;
        end

        tsm_cell u_cell (
            .clk (clk),
            .cmd (cmd_i),
            .up  (up_i),
            .dn1 (dn1_i),
            .dn2 (dn2_i),
            .q   (q[i])
        );
    end

    assign s0 = q[0];
    assign s1 = q[1];

    if (STACK_DEPTH > 2)
    begin : g_s2
        assign s2 = q[2];
    end
    else
    begin : g_s2_none
        assign s2 = '0;
    end

endmodule

/* rtl/tsm_locals.sv */
// ----------------------------------------------------------------------------
// tsm_locals
// Local variable file of tagged values, reset to null.
// ----------------------------------------------------------------------------
module tsm_locals import tsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LIDX_W-1:0] idx,
    input  logic              we,
    input  entry_t            wdata,
    output entry_t            rdata
);

    entry_t loc_reg [LOCAL_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOCAL_COUNT; i++)
            begin
                loc_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            loc_reg[idx] <= wdata;
        end
    end

    assign rdata = loc_reg[idx];

endmodule
